// ===== hdl/i2rd_pkg.sv =====
// Package for the integer to radix digits converter.
// Holds widths, ASCII codes, divider request/response types and character helpers.
// No dependencies.
package i2rd_pkg;

	localparam int VALUE_W        = 32;
	localparam int DAY_W          = 5;
	localparam int CHAR_W         = 8;
	localparam int BASE_W         = 5;
	localparam int DIGIT_W        = 4;
	localparam int BITS_PER_CYCLE = 8;
	localparam int DIV_CYCLES     = VALUE_W / BITS_PER_CYCLE;
	localparam int DIV_STEP_W     = $clog2(DIV_CYCLES);
	localparam int TC_BITS        = 16;
	localparam int ERR_LEN        = 5;

	localparam logic [BASE_W-1:0]  BASE_FULL = 5'd16;
	localparam logic [3:0]         RES_TC    = 4'd1;
	localparam logic [3:0]         TC_TOP    = 4'(TC_BITS - 1);
	localparam logic [3:0]         ERR_TOP   = 4'(ERR_LEN - 1);

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
	localparam logic [CHAR_W-1:0] CH_E     = 8'h45;
	localparam logic [CHAR_W-1:0] CH_R     = 8'h52;
	localparam logic [CHAR_W-1:0] CH_O     = 8'h4F;

	typedef struct packed {
		logic                start;
		logic [BASE_W-1:0]   base;
		logic [VALUE_W-1:0]  dividend;
	} div_req_t;

	typedef struct packed {
		logic                busy;
		logic                done;
		logic [VALUE_W-1:0]  quotient;
		logic [DIGIT_W-1:0]  remainder;
	} div_resp_t;

	// Map one digit to '0'-'9' or 'A'-'F'
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		if (d < 4'd10) begin
			digit_char = CH_ZERO + {4'b0, d};
		end else begin
			digit_char = CH_A + {4'b0, d - 4'd10};
		end
	endfunction

	// Letters of the ERROR text by position
	function automatic logic [CHAR_W-1:0] err_char(input logic [3:0] idx);
		case (idx)
			4'd0:    err_char = CH_E;
			4'd1:    err_char = CH_R;
			4'd2:    err_char = CH_R;
			4'd3:    err_char = CH_O;
			4'd4:    err_char = CH_R;
			default: err_char = CH_E;
		endcase
	endfunction

endpackage

// ===== hdl/i2rd_if.sv =====
// Valid/ready channel interfaces for the converter's input items and output characters.
// Depends on i2rd_pkg for field widths.
interface i2rd_in_if import i2rd_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [VALUE_W-1:0]  value;
	logic        [DAY_W-1:0]    day;

	modport source(output valid, value, day, input ready);
	modport sink(input valid, value, day, output ready);
endinterface

interface i2rd_out_if import i2rd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CHAR_W-1:0]  character;
	logic               error;
	logic               last;

	modport source(output valid, character, error, last, input ready);
	modport sink(input valid, character, error, last, output ready);
endinterface

// ===== hdl/i2rd_divider.sv =====
// Iterative divider: 32-bit dividend by a base of 2 to 16, eight quotient bits per cycle.
// Depends on i2rd_pkg for the request and response types.
module i2rd_divider import i2rd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  div_req_t  req,
	output div_resp_t resp
);

	logic [VALUE_W-1:0]    work_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic                  busy_q;
	logic                  done_q;

	logic [VALUE_W-1:0]    nxt_work;
	logic [DIGIT_W:0]      trial;
	logic [DIGIT_W-1:0]    nxt_rem;

	// Restoring division over one byte of the dividend; quotient bits shift in at the bottom
	always_comb begin
		nxt_work = work_q;
		nxt_rem  = rem_q;
		trial    = '0;
		for (int i = 0; i < BITS_PER_CYCLE; i++) begin
			trial    = {nxt_rem, nxt_work[VALUE_W-1]};
			nxt_work = {nxt_work[VALUE_W-2:0], 1'b0};
			if (trial >= req.base) begin
				trial       = trial - req.base;
				nxt_work[0] = 1'b1;
			end
			nxt_rem = trial[DIGIT_W-1:0];
		end
	end

	// Sequence the byte steps and flag completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == DIV_STEP_W'(DIV_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Load the dividend, then advance the partial result
	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= req.dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			work_q <= nxt_work;
			rem_q  <= nxt_rem;
		end
	end

	assign resp.busy      = busy_q;
	assign resp.done      = done_q;
	assign resp.quotient  = work_q;
	assign resp.remainder = rem_q;

`ifndef SYNTH
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q && !done_q)
		else $error("divider started while a division is in flight");
	a_rem_below_base: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ({1'b0, rem_q} < req.base))
		else $error("remainder not below the base");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("done without a finished division");
`endif

endmodule

// ===== hdl/i2rd_digit_mem.sv =====
// Digit store: one write port, one registered read port, four bits per entry.
// Depends on i2rd_pkg for the digit width.
module i2rd_digit_mem import i2rd_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DIGIT_W-1:0]       wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DIGIT_W-1:0]       rd_data
);

	logic [DIGIT_W-1:0] mem [DEPTH];
	logic [DIGIT_W-1:0] rd_data_q;

	// Write a digit and read one back through a register
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/integer_to_radix_digits.sv =====
// Top level of the integer to radix digits converter: sequencer and output register.
// Depends on i2rd_pkg, i2rd_if, i2rd_divider and i2rd_digit_mem.
//
// Usage: the item channel takes a signed 32-bit value and a day number; the
// result channel returns one ASCII character per transfer, with last on the
// final character of the conversion and error on every letter of ERROR.
// The base is day modulo 16 (zero means 16); a residue of one gives 16 bit
// characters of the 16-bit two's complement form, or ERROR when out of range.
// One item is converted at a time: item.ready is high only while idle.
// In two's complement mode the characters come straight from the held value; in
// the radix modes a sign, if any, is sent first, then every digit is divided
// out and stored before the first digit is read back, most significant first.
// Each digit takes one division (start, four byte steps, done) and is then read
// back through the registered digit store before it is sent. A 32-bit value gives
// at most 32 base-2 digits, 10 decimal ones, or 16 two's complement characters.
// Stalls on the result channel hold the output register and park the
// sequencer at its next character; a division under way still finishes.
// The last character may wait in the output register while the next item is taken.
// Reset clears the sequencer and output valid; the digit store needs no clearing.
module integer_to_radix_digits import i2rd_pkg::*; #(
	parameter int MAX_DIGITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	i2rd_in_if.sink    item,
	i2rd_out_if.source result
);

	localparam int CW = $clog2(MAX_DIGITS + 1);
	localparam int AW = $clog2(MAX_DIGITS);
	localparam logic [CW-1:0] CNT_LIMIT = CW'(MAX_DIGITS - 1);
	localparam logic [CW-1:0] CNT_ONE   = CW'(1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SIGN  = 3'd1;
	localparam logic [2:0] ST_DIVGO = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_RD    = 3'd4;
	localparam logic [2:0] ST_DIG   = 3'd5;
	localparam logic [2:0] ST_TC    = 3'd6;
	localparam logic [2:0] ST_ERR   = 3'd7;

	logic [2:0]          state_q;
	logic [VALUE_W-1:0]  value_q;
	logic [VALUE_W-1:0]  quo_q;
	logic [BASE_W-1:0]   base_q;
	logic [CW-1:0]       cnt_q;
	logic [3:0]          idx_q;

	logic                oval_q;
	logic [CHAR_W-1:0]   char_q;
	logic                err_q;
	logic                last_q;

	logic [3:0]          day_res;
	logic [BASE_W-1:0]   base_in;
	logic                tc_in_range;
	logic [VALUE_W-1:0]  mag_in;
	logic                in_xfer;
	logic                slot_free;
	logic                emit;
	logic [CHAR_W-1:0]   emit_char;
	logic                emit_err;
	logic                emit_last;
	logic                div_more;
	logic [CW-1:0]       cnt_m1;

	div_req_t            div_req;
	div_resp_t           div_resp;
	logic [DIGIT_W-1:0]  rd_digit;

	// Decode the incoming item
	assign day_res     = item.day[3:0];
	assign base_in     = (day_res == 4'd0) ? BASE_FULL : {1'b0, day_res};
	assign tc_in_range = (&item.value[VALUE_W-1:TC_BITS-1]) ||
	                     !(|item.value[VALUE_W-1:TC_BITS-1]);
	assign mag_in      = item.value[VALUE_W-1] ? (~item.value + 1'b1) : item.value;
	assign item.ready  = (state_q == ST_IDLE);
	assign in_xfer     = item.valid && item.ready;

	// Divider hookup and loop condition
	assign div_req.start    = (state_q == ST_DIVGO);
	assign div_req.base     = base_q;
	assign div_req.dividend = quo_q;
	assign div_more = (div_resp.quotient != '0) && (cnt_q < CNT_LIMIT);
	assign cnt_m1   = cnt_q - CNT_ONE;

	i2rd_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.resp   (div_resp)
	);

	i2rd_digit_mem #(.DEPTH(MAX_DIGITS)) u_mem (
		.clk     (clk),
		.wr_en   ((state_q == ST_DIV) && div_resp.done),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (div_resp.remainder),
		.rd_addr (cnt_m1[AW-1:0]),
		.rd_data (rd_digit)
	);

	// Pick the next character for the output register
	assign slot_free = !oval_q || result.ready;
	always_comb begin
		emit      = 1'b0;
		emit_char = CH_ZERO;
		emit_err  = 1'b0;
		emit_last = 1'b0;
		case (state_q)
			ST_SIGN: begin
				emit      = slot_free;
				emit_char = CH_MINUS;
			end
			ST_DIG: begin
				emit      = slot_free;
				emit_char = digit_char(rd_digit);
				emit_last = (cnt_q == CNT_ONE);
			end
			ST_TC: begin
				emit      = slot_free;
				emit_char = CH_ZERO + {7'b0, value_q[idx_q]};
				emit_last = (idx_q == 4'd0);
			end
			ST_ERR: begin
				emit      = slot_free;
				emit_char = err_char(idx_q);
				emit_err  = 1'b1;
				emit_last = (idx_q == ERR_TOP);
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						cnt_q <= '0;
						if (day_res == RES_TC) begin
							idx_q   <= tc_in_range ? TC_TOP : 4'd0;
							state_q <= tc_in_range ? ST_TC : ST_ERR;
						end else begin
							state_q <= item.value[VALUE_W-1] ? ST_SIGN : ST_DIVGO;
						end
					end
				end
				ST_SIGN: begin
					if (emit) begin
						state_q <= ST_DIVGO;
					end
				end
				ST_DIVGO: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_resp.done) begin
						cnt_q   <= cnt_q + CNT_ONE;
						state_q <= div_more ? ST_DIVGO : ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_DIG;
				end
				ST_DIG: begin
					if (emit) begin
						cnt_q   <= cnt_m1;
						state_q <= (cnt_q == CNT_ONE) ? ST_IDLE : ST_RD;
					end
				end
				ST_TC: begin
					if (emit) begin
						idx_q <= idx_q - 4'd1;
						if (idx_q == 4'd0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_ERR: begin
					if (emit) begin
						idx_q <= idx_q + 4'd1;
						if (idx_q == ERR_TOP) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the item and the running quotient
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			value_q <= item.value;
			base_q  <= base_in;
			quo_q   <= mag_in;
		end else if ((state_q == ST_DIV) && div_resp.done) begin
			quo_q <= div_resp.quotient;
		end
	end

	// Output register: load on emit, drop valid after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
		end else if (emit) begin
			oval_q <= 1'b1;
		end else if (result.ready) begin
			oval_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= emit_char;
			err_q  <= emit_err;
			last_q <= emit_last;
		end
	end

	assign result.valid     = oval_q;
	assign result.character = char_q;
	assign result.error     = err_q;
	assign result.last      = last_q;

`ifndef SYNTH
	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !div_resp.busy && !div_resp.done)
		else $error("divider active while the sequencer is idle");
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_resp.done |-> (state_q == ST_DIV))
		else $error("division finished outside the divide state");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_DIGITS))
		else $error("digit count beyond the store depth");
	a_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_RD) || (state_q == ST_DIG)) |-> (cnt_q != '0))
		else $error("digit readout with an empty store");
`endif

endmodule
